// File: rtl/core/sha1_pkg.sv
package sha1_pkg;

	localparam int WordW       = 32;
	localparam int CountW      = 3;
	localparam int LenW        = 64;
	localparam int PosW        = 4;
	localparam int RoundW      = 7;
	localparam int Rounds      = 80;
	localparam int BlockWords  = 16;
	localparam int DigestWords = 5;
	localparam int DigestIdxW  = 3;
	localparam int PhaseLen    = 20;

	localparam logic [WordW-1:0] IV0 = 32'h67452301;
	localparam logic [WordW-1:0] IV1 = 32'hefcdab89;
	localparam logic [WordW-1:0] IV2 = 32'h98badcfe;
	localparam logic [WordW-1:0] IV3 = 32'h10325476;
	localparam logic [WordW-1:0] IV4 = 32'hc3d2e1f0;

	localparam logic [WordW-1:0] K0 = 32'h5a827999;
	localparam logic [WordW-1:0] K1 = 32'h6ed9eba1;
	localparam logic [WordW-1:0] K2 = 32'h8f1bbcdc;
	localparam logic [WordW-1:0] K3 = 32'hca62c1d6;

	localparam logic [7:0]       PAD_BYTE = 8'h80;
	localparam logic [WordW-1:0] PAD_WORD = {PAD_BYTE, 24'h000000};

	typedef struct packed {
		logic [WordW-1:0] a;
		logic [WordW-1:0] b;
		logic [WordW-1:0] c;
		logic [WordW-1:0] d;
		logic [WordW-1:0] e;
	} sha1_vars_t;

	localparam sha1_vars_t IV = '{a: IV0, b: IV1, c: IV2, d: IV3, e: IV4};

	typedef enum logic [1:0] {
		PH_CHOOSE,
		PH_PARITY1,
		PH_MAJORITY,
		PH_PARITY2
	} sha1_phase_t;

	typedef struct packed {
		logic        load;
		logic        step;
		sha1_phase_t phase;
	} sha1_round_ctl_t;

	function automatic logic [WordW-1:0] sha1_k(input sha1_phase_t ph);
		logic [WordW-1:0] k;
		case (ph)
			PH_CHOOSE:   k = K0;
			PH_PARITY1:  k = K1;
			PH_MAJORITY: k = K2;
			default:     k = K3;
		endcase
		return k;
	endfunction

	function automatic logic [WordW-1:0] sha1_f(input sha1_phase_t ph,
		input logic [WordW-1:0] b, input logic [WordW-1:0] c, input logic [WordW-1:0] d);
		logic [WordW-1:0] f;
		case (ph)
			PH_CHOOSE:   f = (b & c) | (~b & d);
			PH_MAJORITY: f = (b & c) | (b & d) | (c & d);
			default:     f = b ^ c ^ d;
		endcase
		return f;
	endfunction

	// Partial last word: keep the leading bytes, append the marker byte.
	function automatic logic [WordW-1:0] sha1_pad_word(input logic [WordW-1:0] w,
		input logic [1:0] nbytes);
		logic [WordW-1:0] p;
		case (nbytes)
			2'd1:    p = {w[31:24], PAD_BYTE, 16'h0000};
			2'd2:    p = {w[31:16], PAD_BYTE, 8'h00};
			2'd3:    p = {w[31:8], PAD_BYTE};
			default: p = PAD_WORD;
		endcase
		return p;
	endfunction

endpackage

// File: rtl/core/sha1_msg_if.sv
interface sha1_msg_if import sha1_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [WordW-1:0]  message_word;
	logic [CountW-1:0] valid_bytes;
	logic              last_word;

	modport source (output valid, output message_word, output valid_bytes, output last_word,
		input ready);
	modport sink (input valid, input message_word, input valid_bytes, input last_word,
		output ready);
endinterface

// File: rtl/core/sha1_digest_if.sv
interface sha1_digest_if import sha1_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [WordW-1:0] digest_word;
	logic             digest_last;

	modport source (output valid, output digest_word, output digest_last, input ready);
	modport sink (input valid, input digest_word, input digest_last, output ready);
endinterface

// File: rtl/core/sha1_sched.sv
module sha1_sched import sha1_pkg::*; (
	input  logic             clk,
	input  logic             shift,
	input  logic             sel_msg,
	input  logic [WordW-1:0] word_in,
	output logic [WordW-1:0] w_cur
);

	logic [WordW-1:0] window_q [BlockWords];
	logic [WordW-1:0] mix;
	logic [WordW-1:0] expand;

	// window_q[0] holds W(t); W(t+16) enters at the top
	assign mix    = window_q[13] ^ window_q[8] ^ window_q[2] ^ window_q[0];
	assign expand = {mix[WordW-2:0], mix[WordW-1]};
	assign w_cur  = window_q[0];

	always_ff @(posedge clk) begin
		if (shift) begin
			for (int i = 0; i < BlockWords - 1; i++) begin
				window_q[i] <= window_q[i+1];
			end
			window_q[BlockWords-1] <= sel_msg ? word_in : expand;
		end
	end

endmodule

// File: rtl/core/sha1_round.sv
module sha1_round import sha1_pkg::*; (
	input  logic             clk,
	input  sha1_round_ctl_t  ctl,
	input  sha1_vars_t       init,
	input  logic [WordW-1:0] w,
	output sha1_vars_t       vars
);

	sha1_vars_t       vars_q;
	sha1_vars_t       vars_next;
	logic [WordW-1:0] t;

	always_comb begin
		t = {vars_q.a[WordW-6:0], vars_q.a[WordW-1:WordW-5]}
			+ sha1_f(ctl.phase, vars_q.b, vars_q.c, vars_q.d)
			+ vars_q.e + w + sha1_k(ctl.phase);
		vars_next.a = t;
		vars_next.b = vars_q.a;
		vars_next.c = {vars_q.b[1:0], vars_q.b[WordW-1:2]};
		vars_next.d = vars_q.c;
		vars_next.e = vars_q.d;
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			vars_q <= init;
		end else if (ctl.step) begin
			vars_q <= vars_next;
		end
	end

	assign vars = vars_q;

endmodule

// File: rtl/core/sha1_hash_engine.sv
// Channel  Role   Payload                                  Transaction
// msg      sink   message_word, valid_bytes, last_word     one message word
// digest   source digest_word, digest_last                 one digest word (h0..h4)
//
// A word is taken in the idle state; every 16th word starts 80 rounds, one per cycle
// in the shared round unit, followed by a fold of the result into the chaining value.
// A last word adds pad words, one or two compressions, then the five digest words.
// msg.ready is low throughout.
// Reset loads the initial chaining value; the digest holds until taken.
module sha1_hash_engine import sha1_pkg::*; (
	input logic          clk,
	input logic          arst_n,
	sha1_msg_if.sink     msg,
	sha1_digest_if.source digest
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ROUND,
		ST_ADD,
		ST_PAD,
		ST_OUT
	} state_t;

	state_t                state_q;
	sha1_vars_t            chain_q;
	logic [LenW-1:0]       len_q;
	logic [PosW-1:0]       pos_q;
	logic [RoundW-1:0]     rnd_q;
	logic [DigestIdxW-1:0] idx_q;
	logic                  padding_q;
	logic                  need_mark_q;
	logic                  hi_done_q;
	logic                  final_q;

	logic                  accept;
	logic [CountW-1:0]     count_eff;
	logic                  push;
	logic [WordW-1:0]      push_word;
	logic                  wraps;
	logic [WordW-1:0]      w_cur;
	sha1_round_ctl_t       rctl;
	sha1_vars_t            vars;

	localparam logic [PosW-1:0]       PosLast  = PosW'(BlockWords - 1);
	localparam logic [PosW-1:0]       PosLenHi = PosW'(BlockWords - 2);
	localparam logic [RoundW-1:0]     RndLast  = RoundW'(Rounds - 1);
	localparam logic [CountW-1:0]     FullCnt  = CountW'(4);
	localparam logic [DigestIdxW-1:0] IdxLast  = DigestIdxW'(DigestWords - 1);

	assign msg.ready = (state_q == ST_IDLE);
	assign accept    = msg.valid && msg.ready;
	assign count_eff = (msg.last_word && msg.valid_bytes <= FullCnt) ? msg.valid_bytes : FullCnt;

	always_comb begin
		push      = 1'b0;
		push_word = '0;
		if (state_q == ST_IDLE && accept) begin
			push = 1'b1;
			if (count_eff == FullCnt) begin
				push_word = msg.message_word;
			end else begin
				push_word = sha1_pad_word(msg.message_word, count_eff[1:0]);
			end
		end else if (state_q == ST_PAD) begin
			push = 1'b1;
			if (need_mark_q) begin
				push_word = PAD_WORD;
			end else if (pos_q == PosLenHi) begin
				push_word = len_q[LenW-1:WordW];
			end else if (pos_q == PosLast && hi_done_q) begin
				push_word = len_q[WordW-1:0];
			end
		end
	end

	assign wraps = push && (pos_q == PosLast);

	always_comb begin
		rctl.load = wraps;
		rctl.step = (state_q == ST_ROUND);
		if (rnd_q < RoundW'(PhaseLen)) begin
			rctl.phase = PH_CHOOSE;
		end else if (rnd_q < RoundW'(2 * PhaseLen)) begin
			rctl.phase = PH_PARITY1;
		end else if (rnd_q < RoundW'(3 * PhaseLen)) begin
			rctl.phase = PH_MAJORITY;
		end else begin
			rctl.phase = PH_PARITY2;
		end
	end

	sha1_sched u_sched (
		.clk     (clk),
		.shift   (push || state_q == ST_ROUND),
		.sel_msg (push),
		.word_in (push_word),
		.w_cur   (w_cur)
	);

	sha1_round u_round (
		.clk  (clk),
		.ctl  (rctl),
		.init (chain_q),
		.w    (w_cur),
		.vars (vars)
	);

	always_comb begin
		case (idx_q)
			DigestIdxW'(0): digest.digest_word = chain_q.a;
			DigestIdxW'(1): digest.digest_word = chain_q.b;
			DigestIdxW'(2): digest.digest_word = chain_q.c;
			DigestIdxW'(3): digest.digest_word = chain_q.d;
			default:        digest.digest_word = chain_q.e;
		endcase
	end

	assign digest.valid       = (state_q == ST_OUT);
	assign digest.digest_last = (idx_q == IdxLast);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			chain_q     <= IV;
			len_q       <= '0;
			pos_q       <= '0;
			rnd_q       <= '0;
			idx_q       <= '0;
			padding_q   <= 1'b0;
			need_mark_q <= 1'b0;
			hi_done_q   <= 1'b0;
			final_q     <= 1'b0;
		end else begin
			if (push) begin
				pos_q <= pos_q + PosW'(1);
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						len_q <= len_q + {{(LenW-CountW-3){1'b0}}, count_eff, 3'b000};
						if (msg.last_word) begin
							padding_q   <= 1'b1;
							need_mark_q <= (count_eff == FullCnt);
						end
						if (wraps) begin
							state_q <= ST_ROUND;
						end else if (msg.last_word) begin
							state_q <= ST_PAD;
						end
					end
				end
				ST_PAD: begin
					if (need_mark_q) begin
						need_mark_q <= 1'b0;
					end else if (pos_q == PosLenHi) begin
						hi_done_q <= 1'b1;
					end else if (pos_q == PosLast && hi_done_q) begin
						final_q <= 1'b1;
					end
					if (wraps) begin
						state_q <= ST_ROUND;
					end
				end
				ST_ROUND: begin
					rnd_q <= rnd_q + RoundW'(1);
					if (rnd_q == RndLast) begin
						rnd_q   <= '0;
						state_q <= ST_ADD;
					end
				end
				ST_ADD: begin
					chain_q.a <= chain_q.a + vars.a;
					chain_q.b <= chain_q.b + vars.b;
					chain_q.c <= chain_q.c + vars.c;
					chain_q.d <= chain_q.d + vars.d;
					chain_q.e <= chain_q.e + vars.e;
					if (final_q) begin
						state_q <= ST_OUT;
					end else if (padding_q) begin
						state_q <= ST_PAD;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_OUT: begin
					if (digest.ready) begin
						idx_q <= idx_q + DigestIdxW'(1);
						if (idx_q == IdxLast) begin
							idx_q     <= '0;
							chain_q   <= IV;
							len_q     <= '0;
							pos_q     <= '0;
							padding_q <= 1'b0;
							hi_done_q <= 1'b0;
							final_q   <= 1'b0;
							state_q   <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
